### hdl/u2u_pkg.sv
// ---------------------------------------------------------------------------
// u2u_pkg
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// ---------------------------------------------------------------------------
package u2u_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned UNIT_W = 16;
    localparam int unsigned ACC_W  = 31;
    localparam int unsigned PEND_W = 3;

    localparam logic [UNIT_W-1:0] HI_SURR_BASE = 16'hD800;
    localparam logic [UNIT_W-1:0] LO_SURR_BASE = 16'hDC00;
    localparam logic [ACC_W-1:0]  SUPP_BASE    = 31'h0001_0000;
    localparam logic [ACC_W-1:0]  MAX_CODE     = 31'h0010_FFFF;

    // number of units one byte produces
    typedef enum logic [1:0] {
        RES_NONE   = 2'd0,
        RES_SINGLE = 2'd1,
        RES_PAIR   = 2'd2
    } res_count_t;

    typedef struct packed {
        logic [UNIT_W-1:0] value;
        logic              last;
        logic              beyond;
    } unit_t;

    typedef struct packed {
        res_count_t count;
        unit_t      first;
        unit_t      second;
    } res_bundle_t;

endpackage

### hdl/u2u_decode.sv
// ---------------------------------------------------------------------------
// u2u_decode
// Sequence state and code point assembly; forms the UTF-16 units for the
// byte being transferred in.
// ---------------------------------------------------------------------------
module u2u_decode (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          byte_en,
    input  logic [u2u_pkg::BYTE_W-1:0]    in_byte,
    input  logic                          string_end,
    output u2u_pkg::res_bundle_t          res
);
    import u2u_pkg::*;

    logic [PEND_W-1:0] pending_reg, pending_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [PEND_W-1:0] pend_upd;
    logic [ACC_W-1:0]  acc_upd;
    logic [ACC_W-1:0]  offs;
    logic              is_supp;
    logic              is_over;

    // lead byte classification, or continuation accumulate
    always_comb begin
        pend_upd = '0;
        acc_upd  = '0;
        if (pending_reg == '0) begin
            priority if (in_byte[7:1] == 7'b1111_110) begin
                pend_upd = 3'd5;
                acc_upd  = ACC_W'(in_byte[0]);
            end else if (in_byte[7:2] == 6'b1111_10) begin
                pend_upd = 3'd4;
                acc_upd  = ACC_W'(in_byte[1:0]);
            end else if (in_byte[7:3] == 5'b1111_0) begin
                pend_upd = 3'd3;
                acc_upd  = ACC_W'(in_byte[2:0]);
            end else if (in_byte[7:4] == 4'b1110) begin
                pend_upd = 3'd2;
                acc_upd  = ACC_W'(in_byte[3:0]);
            end else if (in_byte[7:5] == 3'b110) begin
                pend_upd = 3'd1;
                acc_upd  = ACC_W'(in_byte[4:0]);
            end else begin
                pend_upd = 3'd0;
                acc_upd  = ACC_W'(in_byte);
            end
        end else begin
            pend_upd = pending_reg - 3'd1;
            acc_upd  = {acc_reg[ACC_W-7:0], in_byte[5:0]};
        end
    end

    assign is_supp = (acc_upd >= SUPP_BASE) && (acc_upd <= MAX_CODE);
    assign is_over = (acc_upd > MAX_CODE);
    assign offs    = acc_upd - SUPP_BASE;

    always_comb begin
        res = '0;
        if (pend_upd == '0) begin
            if (is_supp) begin
                res.count         = RES_PAIR;
                res.first.value   = HI_SURR_BASE | UNIT_W'(offs[19:10]);
                res.second.value  = LO_SURR_BASE | UNIT_W'(offs[9:0]);
                res.second.last   = 1'b1;
            end else begin
                res.count         = RES_SINGLE;
                res.first.value   = acc_upd[UNIT_W-1:0];
                res.first.last    = 1'b1;
                res.first.beyond  = is_over;
            end
        end
    end

    // a completed sequence or the end of the string both return to idle
    always_comb begin
        pending_next = pending_reg;
        acc_next     = acc_reg;
        if (byte_en) begin
            if (pend_upd == '0 || string_end) begin
                pending_next = '0;
                acc_next     = '0;
            end else begin
                pending_next = pend_upd;
                acc_next     = acc_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            acc_reg     <= '0;
        end else begin
            pending_reg <= pending_next;
            acc_reg     <= acc_next;
        end
    end

endmodule

### hdl/u2u_outbuf.sv
// ---------------------------------------------------------------------------
// u2u_outbuf
// Two-unit result register; holds a surrogate pair and hands units out one
// transfer at a time.
// ---------------------------------------------------------------------------
module u2u_outbuf (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  u2u_pkg::res_bundle_t     res,
    output logic                     can_push,
    output logic                     m_valid,
    input  logic                     m_ready,
    output u2u_pkg::unit_t           head
);
    import u2u_pkg::*;

    unit_t      slot0_reg, slot0_next;
    unit_t      slot1_reg, slot1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign m_valid  = (cnt_reg != 2'd0);
    assign head     = slot0_reg;
    assign pop      = m_valid && m_ready;
    // free when empty, or once the last held unit leaves in this cycle
    assign can_push = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);

    always_comb begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        if (push) begin
            slot0_next = res.first;
            slot1_next = res.second;
            cnt_next   = 2'(res.count);
        end else if (pop) begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

### hdl/utf8_to_utf16_transcoder_unit.sv
// A completing byte shows its first UTF-16 unit in the cycle after its transfer.
// One byte per cycle while m_tready is high; a surrogate pair holds the input
// while its second unit goes out of the two-unit result register.
// Reset (aresetn low, synchronous) clears the sequence state and empties the
// result register.
// ---------------------------------------------------------------------------
// utf8_to_utf16_transcoder_unit
// UTF-8 byte stream in, UTF-16 code units out.
// ---------------------------------------------------------------------------
module utf8_to_utf16_transcoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // string_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] unit_value
    output logic        m_tlast,   // last_of_run
    output logic        m_tuser    // [0] beyond_range
);
    import u2u_pkg::*;

    res_bundle_t res;
    unit_t       head;
    logic        s_xfer;
    logic        can_push;

    assign s_tready = can_push;
    assign s_xfer   = s_tvalid && s_tready;

    u2u_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_en    (s_xfer),
        .in_byte    (s_tdata),
        .string_end (s_tlast),
        .res        (res)
    );

    u2u_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (s_xfer),
        .res      (res),
        .can_push (can_push),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .head     (head)
    );

    assign m_tdata = head.value;
    assign m_tlast = head.last;
    assign m_tuser = head.beyond;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    a_pair_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && res.count == RES_PAIR) |=> (m_tvalid && !m_tlast && !s_tready))
        else $error("surrogate pair not presented high unit first");

    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && res.count == RES_SINGLE) |=> (m_tvalid && m_tlast))
        else $error("single unit not presented as last of run");

    a_flag_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("range flag on a surrogate unit");

endmodule
